[hw/rtl/rat_acc_pkg.sv]
// rat_acc_pkg: types, codes and constants for the rational accumulator ALU.
// No dependencies; imported by every module of the block.
package rat_acc_pkg;

    // Numeric range of the accumulator
    localparam int WIDTH = 32;

    // Command codes
    localparam logic [3:0] CMD_LOAD    = 4'd0;
    localparam logic [3:0] CMD_ADD     = 4'd1;
    localparam logic [3:0] CMD_SUB     = 4'd2;
    localparam logic [3:0] CMD_MUL     = 4'd3;
    localparam logic [3:0] CMD_DIV     = 4'd4;
    localparam logic [3:0] CMD_SQUARE  = 4'd5;
    localparam logic [3:0] CMD_RECIP   = 4'd6;
    localparam logic [3:0] CMD_NEGATE  = 4'd7;
    localparam logic [3:0] CMD_COMPARE = 4'd8;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIVZERO  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] operand_num;
        logic signed [31:0] operand_den;
    } in_t;

    typedef struct packed {
        logic signed [31:0] result_num;
        logic [30:0]        result_den;
        logic [1:0]         status;
        logic               is_equal;
    } out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMBINE,
        S_RED_INIT,
        S_GCD,
        S_DIV_INIT,
        S_DIV,
        S_FINISH
    } ctrl_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_COMBINE,
        DP_RED_INIT,
        DP_GCD_STEP,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_COMMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [3:0] cmd;
        logic       err;
        logic       n_zero;
        logic       gcd_done;
        logic       div_last;
    } dp_stat_t;

endpackage

[hw/rtl/rational_accumulator_alu_unit.sv]
// Channel  | ports                      | payload
// input    | s_valid, s_ready, s_data   | in_t: command, operand_num, operand_den
// result   | m_valid, m_ready, m_data   | out_t: result_num, result_den, status, is_equal
//
// One transaction at a time; ready while the sequencer is idle, even if a result waits.
// Errors and unused codes go straight to the finish state; compare ends after two
// products; other commands run the gcd loop (one binary gcd step per cycle) and the
// 64-step restoring dividers, which a zero numerator skips.
// Synchronous active-low reset sets the accumulator to 0/1; a stalled result holds.
// Top level; depends on rat_acc_pkg, rat_acc_ctrl and rat_acc_dp.
module rational_accumulator_alu_unit import rat_acc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    dp_cmd_t  ctrl;
    dp_stat_t stat;

    rat_acc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    rat_acc_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .s_data  (s_data),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

[hw/rtl/rat_acc_dp.sv]
// rat_acc_dp: datapath of the rational accumulator (multiplier, gcd, dividers).
// Depends on rat_acc_pkg; sequenced by rat_acc_ctrl.
module rat_acc_dp import rat_acc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  dp_cmd_t  ctrl,
    input  in_t      s_data,
    output dp_stat_t stat,
    output out_t     m_data
);

    localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

    // Accumulator
    logic signed [31:0] acc_num_reg;
    logic [30:0]        acc_den_reg;

    // Captured operand
    logic [3:0]  cmd_reg;
    logic [1:0]  err_reg;
    logic [31:0] bn_reg, bd_reg;
    logic        bneg_reg;

    // Products, reduction operands, gcd and divider state
    logic [63:0] x_reg, y_reg, z_reg;
    logic [63:0] n_reg, d_reg;
    logic        rneg_reg;
    logic [63:0] u_reg, v_reg, g_reg;
    logic [5:0]  k_reg, cnt_reg;
    logic [63:0] qn_reg, qd_reg, rn_reg, rd_reg;
    out_t        out_reg;

    // Accumulator as sign and magnitude
    logic [31:0] an, ad;
    logic        aneg;
    assign aneg = acc_num_reg[31];
    assign an   = aneg ? (32'd0 - acc_num_reg) : acc_num_reg;
    assign ad   = {1'b0, acc_den_reg};

    // Input operand as sign and magnitude
    logic [31:0] in_nm, in_dm;
    logic [1:0]  err_next;
    always_comb begin
        in_nm = s_data.operand_num[31] ? (32'd0 - s_data.operand_num) : s_data.operand_num;
        in_dm = s_data.operand_den[31] ? (32'd0 - s_data.operand_den) : s_data.operand_den;
        err_next = ST_OK;
        if ((s_data.command <= CMD_DIV || s_data.command == CMD_COMPARE) && in_dm == 32'd0)
            err_next = ST_DIVZERO;
        else if (s_data.command == CMD_DIV && in_nm == 32'd0)
            err_next = ST_DIVZERO;
        else if (s_data.command == CMD_RECIP && an == 32'd0)
            err_next = ST_DIVZERO;
    end

    // Shared multiplier operand select
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    always_comb begin
        mul_a = an;
        mul_b = bd_reg;
        case (ctrl.op)
            DP_MUL0: begin
                case (cmd_reg)
                    CMD_MUL:    mul_b = bn_reg;
                    CMD_SQUARE: mul_b = an;
                    default:    mul_b = bd_reg;
                endcase
            end
            DP_MUL1: begin
                mul_a = ad;
                case (cmd_reg)
                    CMD_MUL:    mul_b = bd_reg;
                    CMD_DIV:    mul_b = bn_reg;
                    CMD_SQUARE: mul_b = ad;
                    default:    mul_b = bn_reg;
                endcase
            end
            DP_MUL2: begin
                mul_a = ad;
                mul_b = bd_reg;
            end
            default: begin
                mul_a = an;
                mul_b = bd_reg;
            end
        endcase
    end
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // Combine into numerator, denominator and sign
    logic [63:0] n_next, d_next;
    logic        rneg_next, bs;
    always_comb begin
        bs        = bneg_reg ^ (cmd_reg == CMD_SUB);
        n_next    = x_reg;
        d_next    = y_reg;
        rneg_next = aneg ^ bneg_reg;
        case (cmd_reg)
            CMD_LOAD: begin
                n_next = {32'd0, bn_reg};
                d_next = {32'd0, bd_reg};
                rneg_next = bneg_reg;
            end
            CMD_ADD, CMD_SUB: begin
                d_next = z_reg;
                if (aneg == bs) begin
                    n_next = x_reg + y_reg;
                    rneg_next = aneg;
                end else if (x_reg >= y_reg) begin
                    n_next = x_reg - y_reg;
                    rneg_next = aneg;
                end else begin
                    n_next = y_reg - x_reg;
                    rneg_next = bs;
                end
            end
            CMD_SQUARE: rneg_next = 1'b0;
            CMD_RECIP: begin
                n_next = {32'd0, ad};
                d_next = {32'd0, an};
                rneg_next = aneg;
            end
            CMD_NEGATE: begin
                n_next = {32'd0, an};
                d_next = {32'd0, ad};
                rneg_next = ~aneg;
            end
            default: ;
        endcase
    end

    // Binary gcd step
    logic [63:0] u_next, v_next;
    logic [5:0]  k_next;
    always_comb begin
        u_next = u_reg;
        v_next = v_reg;
        k_next = k_reg;
        if (!u_reg[0] && !v_reg[0]) begin
            u_next = u_reg >> 1;
            v_next = v_reg >> 1;
            k_next = k_reg + 6'd1;
        end else if (!u_reg[0]) begin
            u_next = u_reg >> 1;
        end else if (!v_reg[0]) begin
            v_next = v_reg >> 1;
        end else if (u_reg >= v_reg) begin
            u_next = (u_reg - v_reg) >> 1;
        end else begin
            v_next = (v_reg - u_reg) >> 1;
        end
    end

    // Restoring division step, numerator and denominator in parallel
    logic [64:0] rn_sh, rd_sh, rn_dif, rd_dif;
    assign rn_sh  = {rn_reg, qn_reg[63]};
    assign rd_sh  = {rd_reg, qd_reg[63]};
    assign rn_dif = rn_sh - {1'b0, g_reg};
    assign rd_dif = rd_sh - {1'b0, g_reg};

    // Range check and committed value
    logic        neg_eff, fit, change, beq;
    logic [31:0] num_new;
    always_comb begin
        neg_eff = rneg_reg && (qn_reg != 64'd0);
        fit = (qd_reg != 64'd0) && (qd_reg <= LIM - 64'd1)
              && (qn_reg <= (neg_eff ? LIM : LIM - 64'd1));
        change = (err_reg == ST_OK) && (cmd_reg <= CMD_NEGATE);
        num_new = neg_eff ? (32'd0 - qn_reg[31:0]) : qn_reg[31:0];
        beq = (x_reg == y_reg) && (aneg == (bneg_reg && bn_reg != 32'd0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_num_reg <= '0;
            acc_den_reg <= 31'd1;
        end else if (ctrl.op == DP_COMMIT && change && fit) begin
            acc_num_reg <= num_new;
            acc_den_reg <= qd_reg[30:0];
        end
    end

    // Datapath registers by micro-op
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            DP_CAPTURE: begin
                cmd_reg  <= s_data.command;
                err_reg  <= err_next;
                bn_reg   <= in_nm;
                bd_reg   <= in_dm;
                bneg_reg <= s_data.operand_num[31] ^ s_data.operand_den[31];
            end
            DP_MUL0: x_reg <= mul_p;
            DP_MUL1: y_reg <= mul_p;
            DP_MUL2: z_reg <= mul_p;
            DP_COMBINE: begin
                n_reg    <= n_next;
                d_reg    <= d_next;
                rneg_reg <= rneg_next;
            end
            DP_RED_INIT: begin
                u_reg  <= n_reg;
                v_reg  <= d_reg;
                k_reg  <= '0;
                qn_reg <= '0;
                qd_reg <= 64'd1;
            end
            DP_GCD_STEP: begin
                u_reg <= u_next;
                v_reg <= v_next;
                k_reg <= k_next;
            end
            DP_DIV_INIT: begin
                g_reg   <= v_reg << k_reg;
                qn_reg  <= n_reg;
                qd_reg  <= d_reg;
                rn_reg  <= '0;
                rd_reg  <= '0;
                cnt_reg <= '0;
            end
            DP_DIV_STEP: begin
                cnt_reg <= cnt_reg + 6'd1;
                if (!rn_dif[64]) begin
                    rn_reg <= rn_dif[63:0];
                    qn_reg <= {qn_reg[62:0], 1'b1};
                end else begin
                    rn_reg <= rn_sh[63:0];
                    qn_reg <= {qn_reg[62:0], 1'b0};
                end
                if (!rd_dif[64]) begin
                    rd_reg <= rd_dif[63:0];
                    qd_reg <= {qd_reg[62:0], 1'b1};
                end else begin
                    rd_reg <= rd_sh[63:0];
                    qd_reg <= {qd_reg[62:0], 1'b0};
                end
            end
            DP_COMMIT: begin
                out_reg.is_equal <= (err_reg == ST_OK) && (cmd_reg == CMD_COMPARE) && beq;
                if (change && fit) begin
                    out_reg.result_num <= num_new;
                    out_reg.result_den <= qd_reg[30:0];
                    out_reg.status     <= ST_OK;
                end else begin
                    out_reg.result_num <= acc_num_reg;
                    out_reg.result_den <= acc_den_reg;
                    out_reg.status     <= change ? ST_OVERFLOW : err_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_data        = out_reg;
    assign stat.cmd      = cmd_reg;
    assign stat.err      = (err_reg != ST_OK);
    assign stat.n_zero   = (n_reg == 64'd0);
    assign stat.gcd_done = (u_reg == 64'd0);
    assign stat.div_last = (cnt_reg == 6'h3F);

endmodule

[hw/rtl/rat_acc_ctrl.sv]
// rat_acc_ctrl: sequencer for the rational accumulator datapath.
// Depends on rat_acc_pkg; drives rat_acc_dp through dp_cmd_t.
module rat_acc_ctrl import rat_acc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  ctrl
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_valid) state_next = S_EVAL;
            S_EVAL: begin
                if (stat.err || stat.cmd > CMD_COMPARE)
                    state_next = S_FINISH;
                else if (stat.cmd inside {CMD_LOAD, CMD_RECIP, CMD_NEGATE})
                    state_next = S_COMBINE;
                else
                    state_next = S_MUL0;
            end
            S_MUL0: state_next = S_MUL1;
            S_MUL1: begin
                if (stat.cmd inside {CMD_ADD, CMD_SUB})
                    state_next = S_MUL2;
                else if (stat.cmd == CMD_COMPARE)
                    state_next = S_FINISH;
                else
                    state_next = S_COMBINE;
            end
            S_MUL2:     state_next = S_COMBINE;
            S_COMBINE:  state_next = S_RED_INIT;
            S_RED_INIT: state_next = stat.n_zero ? S_FINISH : S_GCD;
            S_GCD:      if (stat.gcd_done) state_next = S_DIV_INIT;
            S_DIV_INIT: state_next = S_DIV;
            S_DIV:      if (stat.div_last) state_next = S_FINISH;
            S_FINISH:   if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Micro-op per state
    always_comb begin
        ctrl.op = DP_NOP;
        case (state_reg)
            S_IDLE:     if (s_valid) ctrl.op = DP_CAPTURE;
            S_MUL0:     ctrl.op = DP_MUL0;
            S_MUL1:     ctrl.op = DP_MUL1;
            S_MUL2:     ctrl.op = DP_MUL2;
            S_COMBINE:  ctrl.op = DP_COMBINE;
            S_RED_INIT: ctrl.op = DP_RED_INIT;
            S_GCD:      if (!stat.gcd_done) ctrl.op = DP_GCD_STEP;
            S_DIV_INIT: ctrl.op = DP_DIV_INIT;
            S_DIV:      ctrl.op = DP_DIV_STEP;
            S_FINISH:   if (out_free) ctrl.op = DP_COMMIT;
            default:    ctrl.op = DP_NOP;
        endcase
    end

    // State and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_FINISH && out_free)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[hw/rtl/rat_acc_checker.sv]
// rat_acc_checker: port-level assertions for the rational accumulator ALU.
// Depends on rat_acc_pkg; bound to rational_accumulator_alu_unit.
module rat_acc_checker import rat_acc_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // Stalled result stays valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped while stalled");

    // Stalled result holds its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data)) else $error("result changed while stalled");

    // Denominator always positive
    a_den_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.result_den != 31'd0) else $error("zero denominator");

    // Waiting input transaction stays offered with the same payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input transaction changed while waiting");

    // No equality flag on error
    a_eq_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> !m_data.is_equal)
        else $error("is_equal set on error");

endmodule

bind rational_accumulator_alu_unit rat_acc_checker u_rat_acc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
